>>> rtl/core/tpss_pkg.sv
// ----------------------------------------------------------------------------
// tpss_pkg: shared types for the two-thread priority step scheduler
// Task record, cell command codes, result status codes and controller states.
// ----------------------------------------------------------------------------
package tpss_pkg;

	// One task as held in a cell of a thread's chain
	typedef struct packed {
		logic [15:0] value;
		logic [3:0]  prio;
		logic [3:0]  steps;
		logic [3:0]  cur;
	} task_t;

	// Command that a chain applies to its cells
	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INSERT,
		OP_POP,
		OP_STEP
	} chain_op_t;

	// Per-cell control bundle from the chain to one cell
	typedef struct packed {
		chain_op_t op;
		logic      occupied;
		logic      left_keep;
	} cell_ctl_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_STEP     = 2'd0,
		ST_LOADED   = 2'd1,
		ST_REJECTED = 2'd2
	} status_t;

	// Controller states
	typedef enum logic [1:0] {
		S_IDLE,
		S_LOAD,
		S_TICK0,
		S_TICK1
	} state_t;

endpackage

>>> rtl/core/tpss_cell.sv
// ----------------------------------------------------------------------------
// tpss_cell: one task slot of a priority-ordered chain
// Holds one task and takes the new task, its left or right neighbor's task,
// or advances its own step count, as the chain commands.
// ----------------------------------------------------------------------------
module tpss_cell (
	input  logic              clk,
	input  tpss_pkg::cell_ctl_t ctl,
	input  tpss_pkg::task_t   new_task,
	input  tpss_pkg::task_t   left_task,
	input  tpss_pkg::task_t   right_task,
	output logic              keep,
	output tpss_pkg::task_t   slot_q
);
	import tpss_pkg::*;

	// Stay in place on insert when this task ranks at or above the new one
	assign keep = ctl.occupied && (slot_q.prio >= new_task.prio);

	// Shift, insert or step the held task
	always_ff @(posedge clk) begin
		unique case (ctl.op)
			OP_HOLD: ;
			OP_INSERT: begin
				if (!keep) begin
					slot_q <= ctl.left_keep ? new_task : left_task;
				end
			end
			OP_POP: slot_q <= right_task;
			OP_STEP: slot_q.cur <= slot_q.cur + 4'd1;
		endcase
	end

endmodule

>>> rtl/core/tpss_chain.sv
// ----------------------------------------------------------------------------
// tpss_chain: one thread's task table as a sorted row of cells
// Tasks are kept by descending priority, ties in load order, so the head
// cell is always the next task to run.
// ----------------------------------------------------------------------------
module tpss_chain #(
	parameter int TASKS_PER_THREAD = 8
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  tpss_pkg::chain_op_t                    op,
	input  tpss_pkg::task_t                        new_task,
	output tpss_pkg::task_t                        head,
	output logic [$clog2(TASKS_PER_THREAD+1)-1:0]  count
);
	import tpss_pkg::*;

	localparam int N  = TASKS_PER_THREAD;
	localparam int CW = $clog2(N + 1);

	logic [CW-1:0] count_q;
	task_t         slots [N];
	logic          keeps [N];

	// Build the row of cells
	for (genvar i = 0; i < N; i++) begin : g_cell
		cell_ctl_t ctl;
		task_t     left_task;
		task_t     right_task;

		assign ctl.op       = (op == OP_STEP && i != 0) ? OP_HOLD : op;
		assign ctl.occupied = (CW'(i) < count_q);

		if (i == 0) begin : g_first
			assign ctl.left_keep = 1'b1;
			assign left_task     = new_task;
		end else begin : g_inner
			assign ctl.left_keep = keeps[i-1];
			assign left_task     = slots[i-1];
		end

		if (i == N - 1) begin : g_last
			assign right_task = slots[i];
		end else begin : g_mid
			assign right_task = slots[i+1];
		end

		tpss_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.new_task   (new_task),
			.left_task  (left_task),
			.right_task (right_task),
			.keep       (keeps[i]),
			.slot_q     (slots[i])
		);
	end

	// Track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			case (op)
				OP_INSERT: count_q <= count_q + CW'(1);
				OP_POP:    count_q <= count_q - CW'(1);
				default:   count_q <= count_q;
			endcase
		end
	end

	assign head  = slots[0];
	assign count = count_q;

endmodule

>>> rtl/core/two_thread_priority_step_scheduler.sv
// ----------------------------------------------------------------------------
// two_thread_priority_step_scheduler: two-thread static-priority scheduler
// Each of two threads keeps its tasks in a priority-sorted cell chain; a load
// beat inserts a task and a tick beat runs one step on each non-empty thread.
// ----------------------------------------------------------------------------
// A load runs accept, then insert and result, and a tick runs accept, step
// thread 0, step thread 1; either waits while the result side stalls, and
// one beat is in work at a time. Each thread's table is a chain
// of TASKS_PER_THREAD cells kept sorted by priority at insert, so the task to
// run is always the head cell and neither insert nor removal needs a search.
// A tick with both threads empty returns no result beat. The square of a
// finished task comes from one 16x16 multiplier ahead of the result register.
// ----------------------------------------------------------------------------
module two_thread_priority_step_scheduler #(
	parameter int TASKS_PER_THREAD = 8
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        req_valid,
	output logic        req_stall,
	input  logic        kind,
	input  logic        target_thread,
	input  logic [15:0] task_value,
	input  logic [3:0]  task_priority,
	input  logic [3:0]  task_steps,

	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [1:0]  status,
	output logic        thread_index,
	output logic [15:0] run_value,
	output logic [3:0]  run_priority,
	output logic [3:0]  step_done,
	output logic [3:0]  steps_total,
	output logic        finished,
	output logic [31:0] square,
	output logic        last
);
	import tpss_pkg::*;

	localparam int CW = $clog2(TASKS_PER_THREAD + 1);

	state_t        state_q, state_d;
	logic          thr_q;
	logic [15:0]   value_q;
	logic [3:0]    prio_q, steps_q;

	chain_op_t     op0, op1;
	task_t         new_task, head0, head1, head_sel;
	logic [CW-1:0] cnt0, cnt1;
	logic          full;
	logic [3:0]    cur_next;
	logic          fin;
	logic [31:0]   sq;
	logic          out_free, emit;

	status_t       r_status;
	logic          r_thr, r_fin, r_last;
	logic [15:0]   r_value;
	logic [3:0]    r_prio, r_done, r_total;
	logic [31:0]   r_sq;

	logic          rsp_valid_q;
	status_t       status_q;
	logic          thr_out_q, fin_q, last_q;
	logic [15:0]   value_out_q;
	logic [3:0]    prio_out_q, done_q, total_q;
	logic [31:0]   sq_q;

	// Per-thread task chains
	assign new_task = '{value: value_q, prio: prio_q, steps: steps_q, cur: 4'd0};

	tpss_chain #(.TASKS_PER_THREAD(TASKS_PER_THREAD)) u_chain0 (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (op0),
		.new_task (new_task),
		.head     (head0),
		.count    (cnt0)
	);

	tpss_chain #(.TASKS_PER_THREAD(TASKS_PER_THREAD)) u_chain1 (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (op1),
		.new_task (new_task),
		.head     (head1),
		.count    (cnt1)
	);

	// Step the head of the thread in turn
	assign full     = thr_q ? (cnt1 == CW'(TASKS_PER_THREAD))
	                        : (cnt0 == CW'(TASKS_PER_THREAD));
	assign head_sel = (state_q == S_TICK1) ? head1 : head0;
	assign cur_next = head_sel.cur + 4'd1;
	assign fin      = (cur_next >= head_sel.steps);
	assign sq       = fin ? ({16'd0, head_sel.value} * {16'd0, head_sel.value}) : 32'd0;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != S_IDLE);

	// Latch the request beat
	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			thr_q   <= target_thread;
			value_q <= task_value;
			prio_q  <= task_priority;
			steps_q <= task_steps;
		end
	end

	// Advance the controller
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, chain commands and result fields
	always_comb begin
		state_d  = state_q;
		op0      = OP_HOLD;
		op1      = OP_HOLD;
		emit     = 1'b0;
		r_status = ST_STEP;
		r_thr    = 1'b0;
		r_value  = head_sel.value;
		r_prio   = head_sel.prio;
		r_done   = cur_next;
		r_total  = head_sel.steps;
		r_fin    = fin;
		r_sq     = sq;
		r_last   = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_d = kind ? S_TICK0 : S_LOAD;
				end
			end
			S_LOAD: begin
				r_status = full ? ST_REJECTED : ST_LOADED;
				r_thr    = thr_q;
				r_value  = value_q;
				r_prio   = prio_q;
				r_done   = 4'd0;
				r_total  = steps_q;
				r_fin    = 1'b0;
				r_sq     = 32'd0;
				if (out_free) begin
					emit    = 1'b1;
					state_d = S_IDLE;
					if (!full) begin
						if (thr_q) begin
							op1 = OP_INSERT;
						end else begin
							op0 = OP_INSERT;
						end
					end
				end
			end
			S_TICK0: begin
				r_thr  = 1'b0;
				r_last = (cnt1 == '0);
				if (cnt0 == '0) begin
					state_d = S_TICK1;
				end else if (out_free) begin
					emit    = 1'b1;
					op0     = fin ? OP_POP : OP_STEP;
					state_d = S_TICK1;
				end
			end
			S_TICK1: begin
				r_thr = 1'b1;
				if (cnt1 == '0) begin
					state_d = S_IDLE;
				end else if (out_free) begin
					emit    = 1'b1;
					op1     = fin ? OP_POP : OP_STEP;
					state_d = S_IDLE;
				end
			end
		endcase
	end

	// Hold the result beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (emit) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			status_q    <= r_status;
			thr_out_q   <= r_thr;
			value_out_q <= r_value;
			prio_out_q  <= r_prio;
			done_q      <= r_done;
			total_q     <= r_total;
			fin_q       <= r_fin;
			sq_q        <= r_sq;
			last_q      <= r_last;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign status       = status_q;
	assign thread_index = thr_out_q;
	assign run_value    = value_out_q;
	assign run_priority = prio_out_q;
	assign step_done    = done_q;
	assign steps_total  = total_q;
	assign finished     = fin_q;
	assign square       = sq_q;
	assign last         = last_q;

endmodule

>>> tb/tb_two_thread_priority_step_scheduler.sv
// ----------------------------------------------------------------------------
// tb_two_thread_priority_step_scheduler: self-checking scheduler testbench
// Drives load and tick beats with random gaps. A local model of both thread
// tables predicts every step and load report, and the response checker
// compares each result beat with the oldest pending expectation. A short
// table of directed beats runs first, then about 500 random beats.
// ----------------------------------------------------------------------------
module tb_two_thread_priority_step_scheduler;
	timeunit 1ns;
	timeprecision 1ps;

	import tpss_pkg::*;

	localparam int TPT        = 8;
	localparam int RAND_BEATS = 500;
	localparam int LONG_HOLD  = 200;
	localparam int DRAIN      = 8;
	localparam int IDLE_LIMIT = 2000;
	localparam int SHOW_MAX   = 10;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	// How a directed row is checked
	typedef enum logic [1:0] {
		ROW_PREDICT,
		ROW_NONE,
		ROW_ONE
	} row_mode_t;

	typedef struct packed {
		logic        kind;
		logic        thr;
		logic [15:0] value;
		logic [3:0]  prio;
		logic [3:0]  steps;
	} req_beat_t;

	typedef struct packed {
		status_t     status;
		logic        thr;
		logic [15:0] value;
		logic [3:0]  prio;
		logic [3:0]  done;
		logic [3:0]  total;
		logic        fin;
		logic [31:0] sq;
		logic        last;
	} rsp_beat_t;

	typedef struct packed {
		row_mode_t mode;
		req_beat_t stim;
		rsp_beat_t typed;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	logic        kind;
	logic        target_thread;
	logic [15:0] task_value;
	logic [3:0]  task_priority;
	logic [3:0]  task_steps;
	logic        rsp_valid;
	logic        rsp_stall;
	logic [1:0]  status;
	logic        thread_index;
	logic [15:0] run_value;
	logic [3:0]  run_priority;
	logic [3:0]  step_done;
	logic [3:0]  steps_total;
	logic        finished;
	logic [31:0] square;
	logic        last;

	// Scheduler model state
	task_t       sched_tbl [0:2*TPT-1];
	int unsigned sched_cnt [0:1];
	rsp_beat_t   step_res  [0:1];

	rsp_beat_t   pending_q [$];
	dir_row_t    dir_tbl   [$];
	int          err_cnt   = 0;
	bit          burst     = 0;
	bit          hold_long = 0;

	two_thread_priority_step_scheduler #(
		.TASKS_PER_THREAD(TPT)
	) uut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Apply one beat to the model; fills step_res and returns the result count
	function automatic int sched_step(input req_beat_t b);
		int          n;
		int unsigned c;
		int unsigned best;
		int          base;
		task_t       s;
		rsp_beat_t   r;
		logic        fin;

		n = 0;
		if (b.kind == KIND_LOAD) begin
			c = sched_cnt[b.thr];
			r = '0;
			r.thr = b.thr;
			r.value = b.value;
			r.prio = b.prio;
			r.total = b.steps;
			if (c < TPT) begin
				s.value = b.value;
				s.prio = b.prio;
				s.steps = b.steps;
				s.cur = 4'd0;
				sched_tbl[b.thr*TPT + c] = s;
				sched_cnt[b.thr] = c + 1;
				r.status = ST_LOADED;
			end else begin
				r.status = ST_REJECTED;
			end
			step_res[0] = r;
			n = 1;
		end else begin
			for (int t = 0; t < 2; t++) begin
				c = sched_cnt[t];
				base = t*TPT;
				if (c != 0) begin
					// pick highest priority, earliest loaded on a tie
					best = 0;
					for (int unsigned i = 1; i < c; i++)
						if (sched_tbl[base+i].prio > sched_tbl[base+best].prio)
							best = i;
					s = sched_tbl[base+best];
					s.cur = s.cur + 4'd1;
					fin = (s.cur >= s.steps);
					r = '0;
					r.status = ST_STEP;
					r.thr = t[0];
					r.value = s.value;
					r.prio = s.prio;
					r.done = s.cur;
					r.total = s.steps;
					r.fin = fin;
					r.sq = fin ? {16'h0, s.value} * {16'h0, s.value} : 32'h0;
					// drop a finished task and close the gap in load order
					if (fin) begin
						for (int unsigned i = best; i + 1 < c; i++)
							sched_tbl[base+i] = sched_tbl[base+i+1];
						sched_cnt[t] = c - 1;
					end else begin
						sched_tbl[base+best] = s;
					end
					step_res[n] = r;
					n++;
				end
			end
		end
		if (n > 0)
			step_res[n-1].last = 1'b1;
		return n;
	endfunction

	function automatic req_beat_t ld(input logic t, input logic [15:0] v,
			input logic [3:0] p, input logic [3:0] s);
		req_beat_t b;
		b.kind = KIND_LOAD;
		b.thr = t;
		b.value = v;
		b.prio = p;
		b.steps = s;
		return b;
	endfunction

	function automatic req_beat_t tk();
		req_beat_t b;
		b = '0;
		b.kind = KIND_TICK;
		return b;
	endfunction

	function automatic rsp_beat_t res(input status_t st, input logic t,
			input logic [15:0] v, input logic [3:0] p, input logic [3:0] d,
			input logic [3:0] tot, input logic f, input logic [31:0] q);
		rsp_beat_t r;
		r.status = st;
		r.thr = t;
		r.value = v;
		r.prio = p;
		r.done = d;
		r.total = tot;
		r.fin = f;
		r.sq = q;
		r.last = 1'b1;
		return r;
	endfunction

	task automatic add_row(input row_mode_t m, input req_beat_t s, input rsp_beat_t e);
		dir_row_t r;
		r.mode = m;
		r.stim = s;
		r.typed = e;
		dir_tbl = {dir_tbl, r};
	endtask

	function automatic int draw_gap();
		if (burst || $urandom_range(0, 1) == 0)
			return 0;
		return $urandom_range(0, 16);
	endfunction

	// Offer one request beat and hold it until accepted
	task automatic send_beat(input req_beat_t b, input row_mode_t m, input rsp_beat_t e);
		int gap;
		int n;
		gap = draw_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		kind <= b.kind;
		target_thread <= b.thr;
		task_value <= b.value;
		task_priority <= b.prio;
		task_steps <= b.steps;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		n = sched_step(b);
		case (m)
			ROW_PREDICT: begin
				for (int i = 0; i < n; i++)
					pending_q = {pending_q, step_res[i]};
			end
			ROW_ONE: begin
				pending_q = {pending_q, e};
			end
			default: begin
			end
		endcase
	endtask

	// Compare one accepted result beat with the oldest expectation
	task automatic check_rsp();
		rsp_beat_t got;
		rsp_beat_t want;
		got.status = status_t'(status);
		got.thr = thread_index;
		got.value = run_value;
		got.prio = run_priority;
		got.done = step_done;
		got.total = steps_total;
		got.fin = finished;
		got.sq = square;
		got.last = last;
		if (pending_q.size() == 0) begin
			err_cnt++;
			if (err_cnt <= SHOW_MAX)
				$display("unexpected result beat: st=%0d thr=%0d ", got.status, got.thr,
					"val=%h pri=%0d done=%0d", got.value, got.prio, got.done);
		end else begin
			want = pending_q.pop_front();
			if (got !== want) begin
				err_cnt++;
				if (err_cnt <= SHOW_MAX) begin
					$display("mismatch exp: st=%0d thr=%0d val=%h pri=%0d ",
						want.status, want.thr, want.value, want.prio,
						"done=%0d tot=%0d fin=%0b sq=%h last=%0b",
						want.done, want.total, want.fin, want.sq, want.last);
					$display("         got: st=%0d thr=%0d val=%h pri=%0d ",
						got.status, got.thr, got.value, got.prio,
						"done=%0d tot=%0d fin=%0b sq=%h last=%0b",
						got.done, got.total, got.fin, got.sq, got.last);
				end
			end
		end
	endtask

	// Response side: random stalls, one long hold-off on request
	initial begin
		int n;
		rsp_stall <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			n = hold_long ? LONG_HOLD : (burst ? 0 : draw_gap());
			hold_long = 0;
			if (n > 0) begin
				rsp_stall <= 1'b1;
				repeat (n) @(posedge clk);
				rsp_stall <= 1'b0;
			end
			@(posedge clk);
			while (!rsp_valid && !hold_long) @(posedge clk);
			if (rsp_valid)
				check_rsp();
		end
	end

	// Watchdog: end the run when no beat moves for too long
	initial begin
		int idle;
		idle = 0;
		wait (arst_n === 1'b1);
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				idle = 0;
			else
				idle++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		req_beat_t b;
		int        load_pct;

		arst_n = 1'b0;
		req_valid = 1'b0;
		kind = KIND_LOAD;
		target_thread = 1'b0;
		task_value = '0;
		task_priority = '0;
		task_steps = '0;
		sched_cnt[0] = 0;
		sched_cnt[1] = 0;

		// directed rows: empty tick, extremes, full table, ties, zero steps
		add_row(ROW_NONE, tk(), '0);
		add_row(ROW_ONE, ld(1'b0, 16'hFFFF, 4'd15, 4'd1),
			res(ST_LOADED, 1'b0, 16'hFFFF, 4'd15, 4'd0, 4'd1, 1'b0, 32'h0));
		add_row(ROW_ONE, tk(),
			res(ST_STEP, 1'b0, 16'hFFFF, 4'd15, 4'd1, 4'd1, 1'b1, 32'hFFFE0001));
		add_row(ROW_ONE, ld(1'b1, 16'h0000, 4'd0, 4'd0),
			res(ST_LOADED, 1'b1, 16'h0000, 4'd0, 4'd0, 4'd0, 1'b0, 32'h0));
		add_row(ROW_ONE, tk(),
			res(ST_STEP, 1'b1, 16'h0000, 4'd0, 4'd1, 4'd0, 1'b1, 32'h0));
		add_row(ROW_PREDICT, ld(1'b0, 16'h0003, 4'd3, 4'd2), '0);
		add_row(ROW_PREDICT, ld(1'b0, 16'h0107, 4'd7, 4'd1), '0);
		add_row(ROW_PREDICT, ld(1'b0, 16'h0207, 4'd7, 4'd3), '0);
		add_row(ROW_PREDICT, ld(1'b0, 16'h7FFF, 4'd0, 4'd15), '0);
		add_row(ROW_PREDICT, ld(1'b0, 16'h010F, 4'd15, 4'd1), '0);
		add_row(ROW_PREDICT, ld(1'b0, 16'h020F, 4'd15, 4'd2), '0);
		add_row(ROW_PREDICT, ld(1'b0, 16'hC002, 4'd2, 4'd1), '0);
		add_row(ROW_PREDICT, ld(1'b0, 16'h0909, 4'd9, 4'd1), '0);
		add_row(ROW_ONE, ld(1'b0, 16'hA5A5, 4'd10, 4'd15),
			res(ST_REJECTED, 1'b0, 16'hA5A5, 4'd10, 4'd0, 4'd15, 1'b0, 32'h0));
		add_row(ROW_PREDICT, ld(1'b1, 16'h8000, 4'd15, 4'd15), '0);
		add_row(ROW_PREDICT, ld(1'b1, 16'h0001, 4'd15, 4'd2), '0);
		add_row(ROW_PREDICT, ld(1'b1, 16'h5A5A, 4'd0, 4'd0), '0);
		repeat (7) add_row(ROW_PREDICT, tk(), '0);
		add_row(ROW_PREDICT, ld(1'b0, 16'h1234, 4'd15, 4'd1), '0);

		// hold reset, release away from the rising edge
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// walk the directed table
		foreach (dir_tbl[i])
			send_beat(dir_tbl[i].stim, dir_tbl[i].mode, dir_tbl[i].typed);

		// random beats in phases that fill and drain the tables
		for (int i = 0; i < RAND_BEATS; i++) begin
			case ((i / 50) % 3)
				0:       load_pct = 75;
				1:       load_pct = 30;
				default: load_pct = 50;
			endcase
			burst = (i >= 200 && i < 280);
			if (i == 100)
				hold_long = 1;
			// pause the sender until every pending result has drained
			if (i == 350) begin
				req_valid <= 1'b0;
				@(posedge clk);
				while (pending_q.size() != 0) @(posedge clk);
			end
			b.kind = ($urandom_range(0, 99) < load_pct) ? KIND_LOAD : KIND_TICK;
			b.thr = $urandom_range(0, 1);
			b.value = $urandom_range(0, 65535);
			b.prio = $urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(6, 8);
			case ($urandom_range(0, 9))
				0:       b.steps = 4'd0;
				1:       b.steps = 4'd15;
				default: b.steps = $urandom_range(1, 4);
			endcase
			send_beat(b, ROW_PREDICT, '0);
		end
		burst = 0;
		req_valid <= 1'b0;

		// drain, then wait out the DRAIN margin for stray beats
		while (pending_q.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
